>>> hdl/ptt_pkg.sv
// Package for the periodic timer table: request and result item layouts,
// action and result kind codes, and the command format passed to the back end.
// No dependencies.
package ptt_pkg;

  localparam int SLOTS_DEFAULT = 16;

  // Reported firings per run request are capped at this many results.
  localparam int RES_MAX = 16;
  localparam int FIRE_W  = $clog2(RES_MAX + 1);

  localparam logic [31:0] SAT32 = 32'hffff_ffff;

  // Action codes of a request.
  localparam logic [1:0] ACT_RUN    = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_INIT   = 2'd3;

  // Kind codes of a result.
  localparam logic [2:0] KIND_FIRED       = 3'd0;
  localparam logic [2:0] KIND_NONE_FIRED  = 3'd1;
  localparam logic [2:0] KIND_CREATED     = 3'd2;
  localparam logic [2:0] KIND_CREATE_FAIL = 3'd3;
  localparam logic [2:0] KIND_REMOVED     = 3'd4;
  localparam logic [2:0] KIND_NOT_FOUND   = 3'd5;
  localparam logic [2:0] KIND_INIT_DONE   = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] timestamp;
    logic [15:0] interval;
    logic        has_handler;
    logic [3:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] timer_slot;
    logic [4:0] timer_count;
    logic       last;
  } out_item_t;

  // Classified command held in the queue between front and back end.
  typedef enum logic [2:0] {
    CMD_RUN,
    CMD_CREATE,
    CMD_REJECT,
    CMD_REMOVE,
    CMD_INIT
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [31:0] timestamp;
    logic [15:0] interval;
    logic        has_handler;
    logic [3:0]  slot;
  } cmd_t;

endpackage

>>> hdl/ptt_front.sv
// Front end of the periodic timer table: accepts requests, classifies them
// into commands and holds them in a two-entry queue.
// Depends on ptt_pkg.
module ptt_front import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     request_valid,
  output logic     request_stall,
  input  in_item_t request,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       entry [2];
  logic       head;
  logic       tail;
  logic [1:0] fill;
  logic       push;
  cmd_t       classified;

  assign request_stall = (fill == 2'd2);
  assign push          = request_valid && !request_stall;
  assign cmd_valid     = (fill != 2'd0);
  assign cmd           = entry[head];

  // A create with a zero interval is rejected here; everything else that
  // depends on table contents is decided by the back end.
  always_comb begin
    classified.timestamp   = request.timestamp;
    classified.interval    = request.interval;
    classified.has_handler = request.has_handler;
    classified.slot        = request.slot;
    case (request.action)
      ACT_RUN:    classified.op = CMD_RUN;
      ACT_CREATE: classified.op = (request.interval == 16'd0) ? CMD_REJECT : CMD_CREATE;
      ACT_REMOVE: classified.op = CMD_REMOVE;
      ACT_INIT:   classified.op = CMD_INIT;
      default:    classified.op = CMD_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (cmd_pop) begin
        head <= ~head;
      end
      case ({push, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
    if (push) begin
      entry[tail] <= classified;
    end
  end

endmodule

>>> hdl/ptt_back.sv
// Back end of the periodic timer table: timer and order memories, the
// sequencer that runs, creates and removes timers, and the result register.
// Depends on ptt_pkg.
module ptt_back import ptt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [15:0] period;
    logic [31:0] accumulated;
    logic        reports;
  } row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SCAN,
    S_REMOVE
  } state_t;

  row_t            timer_mem [SLOTS];
  logic [SW-1:0]   order_mem [SLOTS];

  state_t          state;
  logic [SLOTS-1:0] in_use;
  logic [CW-1:0]   present_count;
  logic [31:0]     last_stamp;
  logic [31:0]     elapsed;
  logic [CW-1:0]   rd_idx;
  logic [CW-1:0]   p1_pos;
  logic            p1_v;
  logic            p2_v;
  logic [SW-1:0]   ord_q;
  logic [SW-1:0]   p2_slot;
  row_t            row_q;
  logic            held_v;
  logic [SW-1:0]   held_slot;
  logic [FIRE_W-1:0] fire_n;
  logic [15:0]     new_period;
  logic            new_reports;
  logic [SW-1:0]   scan_idx;
  logic [SW-1:0]   rm_slot;
  logic            found;

  logic            adv;
  logic            rd_more;
  logic            req_out_of_range;
  logic [SW-1:0]   req_idx;
  logic [32:0]     sum;
  logic [31:0]     acc_sat;
  logic            expired;
  logic            reportable;
  logic            tm_we;
  logic [SW-1:0]   tm_waddr;
  row_t            tm_wdata;
  logic            om_we;
  logic [SW-1:0]   om_waddr;
  logic [SW-1:0]   om_wdata;
  logic            out_load;
  out_item_t       out_next;

  // The whole back end holds while a finished result waits to be taken.
  assign adv              = !result_valid || !result_stall;
  assign cmd_pop          = (state == S_IDLE) && cmd_valid && adv;
  assign rd_more          = (rd_idx < present_count);
  assign req_out_of_range = (32'(cmd.slot) >= SLOTS);
  assign req_idx          = SW'(cmd.slot);

  // Saturating add of the elapsed time, then the period compare.
  assign sum        = {1'b0, row_q.accumulated} + {1'b0, elapsed};
  assign acc_sat    = sum[32] ? SAT32 : sum[31:0];
  assign expired    = (acc_sat >= {16'd0, row_q.period});
  assign reportable = expired && row_q.reports && (fire_n < FIRE_W'(RES_MAX));

  always_comb begin
    tm_we    = 1'b0;
    tm_waddr = p2_slot;
    tm_wdata = row_q;
    om_we    = 1'b0;
    om_waddr = present_count[SW-1:0];
    om_wdata = scan_idx;
    out_load = 1'b0;
    out_next.kind        = KIND_NONE_FIRED;
    out_next.timer_slot  = 4'd0;
    out_next.timer_count = 5'(present_count);
    out_next.last        = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          case (cmd.op)
            CMD_CREATE: begin
              if (present_count >= CW'(SLOTS)) begin
                out_load      = 1'b1;
                out_next.kind = KIND_CREATE_FAIL;
              end
            end
            CMD_REJECT: begin
              out_load      = 1'b1;
              out_next.kind = KIND_CREATE_FAIL;
            end
            CMD_REMOVE: begin
              if (req_out_of_range || !in_use[req_idx]) begin
                out_load            = 1'b1;
                out_next.kind       = KIND_NOT_FOUND;
                out_next.timer_slot = cmd.slot;
              end
            end
            CMD_INIT: begin
              out_load             = 1'b1;
              out_next.kind        = KIND_INIT_DONE;
              out_next.timer_count = 5'd0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (adv && !in_use[scan_idx]) begin
          tm_we                = 1'b1;
          tm_waddr             = scan_idx;
          tm_wdata.period      = new_period;
          tm_wdata.accumulated = 32'd0;
          tm_wdata.reports     = new_reports;
          om_we                = 1'b1;
          out_load             = 1'b1;
          out_next.kind        = KIND_CREATED;
          out_next.timer_slot  = 4'(scan_idx);
          out_next.timer_count = 5'(present_count + 1'b1);
        end
      end
      S_REMOVE: begin
        // Every entry behind the removed one moves up by one place.
        if (adv && p1_v && found) begin
          om_we    = 1'b1;
          om_waddr = SW'(p1_pos - CW'(1));
          om_wdata = ord_q;
        end
        if (adv && !rd_more && !p1_v) begin
          out_load             = 1'b1;
          out_next.kind        = KIND_REMOVED;
          out_next.timer_slot  = 4'(rm_slot);
          out_next.timer_count = 5'(present_count - 1'b1);
        end
      end
      S_RUN: begin
        if (adv && p2_v) begin
          tm_we                = 1'b1;
          tm_wdata.accumulated = expired ? 32'd0 : acc_sat;
          // A new firing pushes out the one held back, which is then not last.
          if (reportable && held_v) begin
            out_load            = 1'b1;
            out_next.kind       = KIND_FIRED;
            out_next.timer_slot = 4'(held_slot);
            out_next.last       = 1'b0;
          end
        end
        if (adv && !rd_more && !p1_v && !p2_v) begin
          out_load = 1'b1;
          if (held_v) begin
            out_next.kind       = KIND_FIRED;
            out_next.timer_slot = 4'(held_slot);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      timer_mem[tm_waddr] <= tm_wdata;
    end
    if (adv) begin
      row_q <= timer_mem[ord_q];
    end
  end

  always_ff @(posedge clk) begin
    if (om_we) begin
      order_mem[om_waddr] <= om_wdata;
    end
    if (adv) begin
      ord_q <= order_mem[rd_idx[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_use        <= '0;
      present_count <= '0;
      last_stamp    <= '0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      held_v        <= 1'b0;
      found         <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (adv) begin
        case (state)
          S_IDLE: begin
            if (cmd_valid) begin
              case (cmd.op)
                CMD_RUN: begin
                  elapsed    <= cmd.timestamp - last_stamp;
                  last_stamp <= cmd.timestamp;
                  rd_idx     <= '0;
                  p1_v       <= 1'b0;
                  p2_v       <= 1'b0;
                  held_v     <= 1'b0;
                  fire_n     <= '0;
                  state      <= S_RUN;
                end
                CMD_CREATE: begin
                  new_period  <= cmd.interval;
                  new_reports <= cmd.has_handler;
                  scan_idx    <= '0;
                  if (present_count < CW'(SLOTS)) begin
                    state <= S_SCAN;
                  end
                end
                CMD_REMOVE: begin
                  rm_slot <= req_idx;
                  rd_idx  <= '0;
                  p1_v    <= 1'b0;
                  found   <= 1'b0;
                  if (!req_out_of_range && in_use[req_idx]) begin
                    state <= S_REMOVE;
                  end
                end
                CMD_INIT: begin
                  in_use        <= '0;
                  present_count <= '0;
                  last_stamp    <= cmd.timestamp;
                end
                default: ;
              endcase
            end
          end
          S_SCAN: begin
            if (!in_use[scan_idx]) begin
              in_use[scan_idx] <= 1'b1;
              present_count    <= present_count + 1'b1;
              state            <= S_IDLE;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          S_REMOVE: begin
            if (rd_more) begin
              rd_idx <= rd_idx + 1'b1;
            end
            p1_v   <= rd_more;
            p1_pos <= rd_idx;
            if (p1_v && (ord_q == rm_slot)) begin
              found <= 1'b1;
            end
            if (!rd_more && !p1_v) begin
              in_use[rm_slot] <= 1'b0;
              present_count   <= present_count - 1'b1;
              state           <= S_IDLE;
            end
          end
          S_RUN: begin
            if (rd_more) begin
              rd_idx <= rd_idx + 1'b1;
            end
            p1_v    <= rd_more;
            p2_v    <= p1_v;
            p2_slot <= ord_q;
            if (p2_v && reportable) begin
              held_v    <= 1'b1;
              held_slot <= p2_slot;
              fire_n    <= fire_n + 1'b1;
            end
            if (!rd_more && !p1_v && !p2_v) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
      if (out_load) begin
        result <= out_next;
      end
    end
  end

  // The timer count always equals the number of occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    int'(present_count) == $countones(in_use))
    else $error("timer count differs from occupied slots");

  // The second run stage only carries data while a run is in progress.
  a_stage2_in_run: assert property (@(posedge clk) disable iff (rst)
    p2_v |-> (state == S_RUN))
    else $error("run stage active outside a run");

  // A fire result is only ever pushed out from the held firing.
  a_fire_from_held: assert property (@(posedge clk) disable iff (rst)
    (out_load && (out_next.kind == KIND_FIRED)) |-> held_v)
    else $error("fire result without a held firing");

  // The removed slot is always found in the creation order.
  a_remove_found: assert property (@(posedge clk) disable iff (rst)
    ((state == S_REMOVE) && !rd_more && !p1_v) |-> found)
    else $error("removed slot missing from creation order");

  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (fire_n <= FIRE_W'(RES_MAX)))
    else $error("fire count above the result limit");

endmodule

>>> hdl/periodic_timer_table.sv
// Periodic timer table: a run reads one present timer per cycle through the order and timer
// memory read ports while no finished result waits to be taken; remove walks the same order,
// and create takes the lowest free slot index. Init and rejected requests give their result
// in the cycle after leaving the queue. A two-entry queue lets up to two further requests be
// accepted while one is in progress. Synchronous active-high reset empties the table, clears
// the stamp and the queue; no memory clearing pass is needed.
module periodic_timer_table import ptt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      request_valid,
  output logic      request_stall,
  input  in_item_t  request,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  // Classified commands cross from the front end to the back end through
  // the queue; the back end pops one only when it is idle and its result
  // register can take a new result.
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // The front end decodes the action and rejects a zero-interval create
  // before the request reaches the back end.
  ptt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // The back end owns the timer table. A run walks the creation order,
  // reading a slot number and then its timer row, and writes the updated
  // accumulated time back while the next timer is being read. Each fire
  // result is held one step so that the final one can carry the last mark;
  // a run with no reported firing gives a single none-fired result.
  ptt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
